### src/rcspm_pkg.sv
// Shared types, register codes and widths for the servo pulse mapper.
// Depends on nothing; every other file of the block imports it.
package rcspm_pkg;

	// Port widths.
	localparam int VAL_W      = 16;
	localparam int PW_W       = 12;
	localparam int PCT_W      = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Mode codes. The spare code behaves as angle mode.
	localparam logic [1:0] MODE_RANGE = 2'd0;
	localparam logic [1:0] MODE_ANGLE = 2'd1;
	localparam logic [1:0] MODE_RAW   = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSED   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_TRIM = 3'd6;

	// Register values after reset.
	localparam logic [1:0]        RST_MODE       = MODE_ANGLE;
	localparam logic              RST_REVERSED   = 1'b0;
	localparam logic [VAL_W-1:0]  RST_SPAN_LOW   = 16'd0;
	localparam logic [VAL_W-1:0]  RST_SPAN_HIGH  = 16'd4500;
	localparam logic [PW_W-1:0]   RST_PULSE_MIN  = 12'd1100;
	localparam logic [PW_W-1:0]   RST_PULSE_MAX  = 12'd1900;
	localparam logic [PW_W-1:0]   RST_PULSE_TRIM = 12'd1500;

	// Main divider: the rounded numerator 2|n|+|d| stays below 2^30 and the
	// doubled divisor below 2^17. The product magnitude stays below 2^28.
	localparam int DIV_NUM_W = 30;
	localparam int DIV_DEN_W = 17;
	localparam int DIV_STEPS = DIV_NUM_W;
	localparam int MAG_W     = 28;
	localparam int DMAG_W    = 16;
	localparam int TERM_W    = 30;
	localparam logic [DIV_DEN_W-1:0] RAW_DIVISOR = 17'd10;

	// Percent divider: 100 times a 12-bit offset, seven quotient bits.
	localparam int PNUM_W    = 19;
	localparam int PCT_STEPS = PCT_W;
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	// Percent selection codes.
	localparam logic [1:0] PCT_LOW  = 2'd0;
	localparam logic [1:0] PCT_HIGH = 2'd1;
	localparam logic [1:0] PCT_MID  = 2'd2;

	// Pipeline depth from accepted start to the done strobe.
	localparam int FRONT_STAGES = 4;
	localparam int POST_STAGES  = 4;
	localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STEPS + POST_STAGES + PCT_STEPS + 1;

	typedef struct packed {
		logic [1:0]              mode;
		logic                    reversed;
		logic signed [VAL_W-1:0] span_low;
		logic signed [VAL_W-1:0] span_high;
		logic [PW_W-1:0]         pulse_min;
		logic [PW_W-1:0]         pulse_max;
		logic [PW_W-1:0]         pulse_trim;
	} cfg_t;

	typedef struct packed {
		logic                 valid;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
		logic                 neg;
	} div_req_t;

	typedef struct packed {
		logic                 valid;
		logic [DIV_NUM_W-1:0] quo;
		logic                 neg;
	} div_rsp_t;

	typedef struct packed {
		logic [PW_W-1:0] pulse;
		logic            clamped;
		logic [1:0]      sel;
	} pct_ctx_t;

	typedef struct packed {
		logic              valid;
		logic [PNUM_W-1:0] pnum;
		pct_ctx_t          ctx;
	} pct_req_t;

endpackage

### src/rcspm_front.sv
// Front end of the mapper: operand selection, signed multiply, magnitudes
// and the rounded-division operands. Depends on rcspm_pkg.
module rcspm_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [rcspm_pkg::VAL_W-1:0] control_value,
	input  rcspm_pkg::cfg_t                 cfg,
	output rcspm_pkg::div_req_t             req
);
	import rcspm_pkg::*;

	logic signed [VAL_W:0]  v_ext;
	logic signed [VAL_W:0]  v_rev;
	logic signed [VAL_W:0]  a_d;
	logic signed [PW_W:0]   k_d;
	logic signed [VAL_W:0]  den_d;
	logic signed [PW_W:0]   mx_e;
	logic signed [PW_W:0]   mn_e;
	logic signed [PW_W:0]   tr_e;

	logic                   valid_s1;
	logic signed [VAL_W:0]  a_s1;
	logic signed [PW_W:0]   k_s1;
	logic signed [VAL_W:0]  den_s1;

	logic                   valid_s2;
	logic signed [TERM_W-1:0] prod_s2;
	logic signed [VAL_W:0]  den_s2;

	logic signed [TERM_W-1:0] prod_neg;
	logic signed [VAL_W:0]  den_neg;

	logic                   valid_s3;
	logic [MAG_W-1:0]       mag_s3;
	logic [DMAG_W-1:0]      dmag_s3;
	logic                   neg_s3;

	logic                   valid_s4;
	logic [DIV_NUM_W-1:0]   num_s4;
	logic [DIV_DEN_W-1:0]   den_s4;
	logic                   neg_s4;

	// Pick the multiplicand, slope and divisor for the active mode.
	always_comb begin
		v_ext = {control_value[VAL_W-1], control_value};
		v_rev = cfg.reversed ? -v_ext : v_ext;
		mx_e  = {1'b0, cfg.pulse_max};
		mn_e  = {1'b0, cfg.pulse_min};
		tr_e  = {1'b0, cfg.pulse_trim};
		unique case (cfg.mode)
			MODE_RANGE: begin
				a_d   = v_ext - {cfg.span_low[VAL_W-1], cfg.span_low};
				k_d   = mx_e - mn_e;
				den_d = {cfg.span_high[VAL_W-1], cfg.span_high}
					- {cfg.span_low[VAL_W-1], cfg.span_low};
			end
			MODE_RAW: begin
				// Sign of the reverse flag rides on the multiplier.
				a_d   = v_ext;
				k_d   = cfg.reversed ? -13'sd1 : 13'sd1;
				den_d = '0;
			end
			default: begin
				a_d   = v_rev;
				k_d   = (v_rev > 17'sd0) ? (mx_e - tr_e) : (tr_e - mn_e);
				den_d = {cfg.span_high[VAL_W-1], cfg.span_high};
			end
		endcase
	end

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Magnitudes for the sign-magnitude divider.
	always_comb begin
		prod_neg = -prod_s2;
		den_neg  = -den_s2;
	end

	// Payload of the front stages.
	always_ff @(posedge clk) begin
		a_s1   <= a_d;
		k_s1   <= k_d;
		den_s1 <= den_d;

		prod_s2 <= a_s1 * k_s1;
		den_s2  <= den_s1;

		mag_s3  <= prod_s2[TERM_W-1] ? prod_neg[MAG_W-1:0] : prod_s2[MAG_W-1:0];
		dmag_s3 <= den_s2[VAL_W] ? den_neg[DMAG_W-1:0] : den_s2[DMAG_W-1:0];
		neg_s3  <= prod_s2[TERM_W-1] ^ den_s2[VAL_W];

		// Raw: |n| / 10 truncated. Else half away from zero: floor((2|n|+|d|)/2|d|).
		if (cfg.mode == MODE_RAW) begin
			num_s4 <= {2'b00, mag_s3};
			den_s4 <= RAW_DIVISOR;
		end else begin
			num_s4 <= {1'b0, mag_s3, 1'b0} + {{(DIV_NUM_W - DMAG_W){1'b0}}, dmag_s3};
			den_s4 <= {dmag_s3, 1'b0};
		end
		neg_s4 <= neg_s3;
	end

	assign req.valid = valid_s4;
	assign req.num   = num_s4;
	assign req.den   = den_s4;
	assign req.neg   = neg_s4;

endmodule

### src/rcspm_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned operands
// with a sign bit carried alongside. Depends on rcspm_pkg.
module rcspm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rcspm_pkg::div_req_t req,
	output rcspm_pkg::div_rsp_t rsp
);
	import rcspm_pkg::*;

	typedef struct packed {
		logic [DIV_DEN_W-1:0] rem;
		logic [DIV_NUM_W-1:0] nq;
		logic [DIV_DEN_W-1:0] den;
		logic                 neg;
	} div_stage_t;

	logic       valid_s [DIV_STEPS];
	div_stage_t stage_s [DIV_STEPS];
	logic       valid_d [DIV_STEPS];
	div_stage_t stage_d [DIV_STEPS];

	// One compare and subtract per stage; the numerator shifts out on the
	// left while quotient bits shift in on the right.
	always_comb begin
		div_stage_t           prev;
		logic                 prev_valid;
		logic [DIV_DEN_W:0]   shifted;
		logic [DIV_DEN_W:0]   diff;
		logic                 ge;
		for (int i = 0; i < DIV_STEPS; i++) begin
			if (i == 0) begin
				prev_valid = req.valid;
				prev.rem   = '0;
				prev.nq    = req.num;
				prev.den   = req.den;
				prev.neg   = req.neg;
			end else begin
				prev_valid = valid_s[i-1];
				prev       = stage_s[i-1];
			end
			shifted = {prev.rem, prev.nq[DIV_NUM_W-1]};
			diff    = shifted - {1'b0, prev.den};
			ge      = (shifted >= {1'b0, prev.den});
			valid_d[i]     = prev_valid;
			stage_d[i].rem = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
			stage_d[i].nq  = {prev.nq[DIV_NUM_W-2:0], ge};
			stage_d[i].den = prev.den;
			stage_d[i].neg = prev.neg;
		end
	end

	// Valid bits travel with each stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STEPS; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else begin
			for (int i = 0; i < DIV_STEPS; i++) begin
				valid_s[i] <= valid_d[i];
			end
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		for (int i = 0; i < DIV_STEPS; i++) begin
			stage_s[i] <= stage_d[i];
		end
	end

	assign rsp.valid = valid_s[DIV_STEPS-1];
	assign rsp.quo   = stage_s[DIV_STEPS-1].nq;
	assign rsp.neg   = stage_s[DIV_STEPS-1].neg;

endmodule

### src/rcspm_post.sv
// Back end of the mapper: signed term, unclamped pulse, clamp and the
// percent numerator. Depends on rcspm_pkg.
module rcspm_post (
	input  logic                clk,
	input  logic                arst_n,
	input  rcspm_pkg::div_rsp_t rsp,
	input  rcspm_pkg::cfg_t     cfg,
	output rcspm_pkg::pct_req_t req
);
	import rcspm_pkg::*;

	logic signed [TERM_W-1:0] q_mag;
	logic signed [TERM_W-1:0] term_d;
	logic signed [TERM_W-1:0] mn_w;
	logic signed [TERM_W-1:0] mx_w;
	logic signed [TERM_W-1:0] tr_w;
	logic signed [TERM_W-1:0] o_d;

	logic                     valid_s1;
	logic signed [TERM_W-1:0] term_s1;
	logic                     valid_s2;
	logic signed [TERM_W-1:0] o_s2;
	logic                     valid_s3;
	pct_ctx_t                 ctx_s3;
	logic [PW_W-1:0]          pdiff_s3;
	pct_ctx_t                 ctx_d;
	logic                     valid_s4;
	logic [PNUM_W-1:0]        pnum_s4;
	pct_ctx_t                 ctx_s4;

	// Quotient is below 2^29 for a nonzero divisor, so its top bit is clear.
	always_comb begin
		mn_w  = {{(TERM_W - PW_W){1'b0}}, cfg.pulse_min};
		mx_w  = {{(TERM_W - PW_W){1'b0}}, cfg.pulse_max};
		tr_w  = {{(TERM_W - PW_W){1'b0}}, cfg.pulse_trim};
		q_mag = {1'b0, rsp.quo[TERM_W-2:0]};
		term_d = rsp.neg ? -q_mag : q_mag;
		unique case (cfg.mode)
			MODE_RANGE: begin
				// A zero span uses the trim value as the term.
				if (cfg.span_high == cfg.span_low) begin
					term_d = tr_w;
				end
			end
			MODE_RAW: begin
				term_d = rsp.neg ? -q_mag : q_mag;
			end
			default: begin
				// A zero full-scale value gives no deflection.
				if (cfg.span_high == 16'sd0) begin
					term_d = '0;
				end
			end
		endcase
	end

	// Unclamped pulse.
	always_comb begin
		if (cfg.mode == MODE_RANGE) begin
			o_d = cfg.reversed ? (mx_w - term_s1) : (mn_w + term_s1);
		end else begin
			o_d = term_s1 + tr_w;
		end
	end

	// Clamp and percent case. With min above max the result is one bound.
	always_comb begin
		if (o_s2 < mn_w) begin
			ctx_d.pulse = cfg.pulse_min;
		end else if (o_s2 > mx_w) begin
			ctx_d.pulse = cfg.pulse_max;
		end else begin
			ctx_d.pulse = o_s2[PW_W-1:0];
		end
		ctx_d.clamped = (o_s2 < mn_w) || (o_s2 > mx_w);
		if (o_s2 <= mn_w) begin
			ctx_d.sel = PCT_LOW;
		end else if (o_s2 >= mx_w) begin
			ctx_d.sel = PCT_HIGH;
		end else begin
			ctx_d.sel = PCT_MID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= rsp.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		term_s1  <= term_d;
		o_s2     <= o_d;
		ctx_s3   <= ctx_d;
		pdiff_s3 <= o_s2[PW_W-1:0] - cfg.pulse_min;
		// Scaling by one hundred is a constant multiply.
		pnum_s4  <= PNUM_W'(pdiff_s3) * PNUM_W'(PCT_FULL);
		ctx_s4   <= ctx_s3;
	end

	assign req.valid = valid_s4;
	assign req.pnum  = pnum_s4;
	assign req.ctx   = ctx_s4;

endmodule

### src/rcspm_pct.sv
// Percent divider and output register: seven restoring steps of
// 100*(out-min)/(max-min), then the reverse-aware percent. Depends on rcspm_pkg.
module rcspm_pct (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rcspm_pkg::pct_req_t    req,
	input  rcspm_pkg::cfg_t        cfg,
	output logic                   done,
	output logic [rcspm_pkg::PW_W-1:0]  pulse_width,
	output logic                   was_clamped,
	output logic [rcspm_pkg::PCT_W-1:0] percent_position
);
	import rcspm_pkg::*;

	typedef struct packed {
		logic [PW_W-1:0]  rem;
		logic [PCT_W-1:0] nq;
		pct_ctx_t         ctx;
	} pct_stage_t;

	logic [PW_W-1:0]  span;
	logic             valid_s [PCT_STEPS];
	pct_stage_t       stage_s [PCT_STEPS];
	logic             valid_d [PCT_STEPS];
	pct_stage_t       stage_d [PCT_STEPS];
	logic [PCT_W-1:0] pct_d;
	logic             done_s8;
	logic [PW_W-1:0]  pulse_s8;
	logic             clamped_s8;
	logic [PCT_W-1:0] pct_s8;

	// Only the mid case is used, where out-min < max-min, so the quotient
	// fits seven bits and the top twelve numerator bits start below the span.
	assign span = cfg.pulse_max - cfg.pulse_min;

	always_comb begin
		pct_stage_t     prev;
		logic           prev_valid;
		logic [PW_W:0]  shifted;
		logic [PW_W:0]  diff;
		logic           ge;
		for (int i = 0; i < PCT_STEPS; i++) begin
			if (i == 0) begin
				prev_valid = req.valid;
				prev.rem   = req.pnum[PNUM_W-1:PCT_W];
				prev.nq    = req.pnum[PCT_W-1:0];
				prev.ctx   = req.ctx;
			end else begin
				prev_valid = valid_s[i-1];
				prev       = stage_s[i-1];
			end
			shifted = {prev.rem, prev.nq[PCT_W-1]};
			diff    = shifted - {1'b0, span};
			ge      = (shifted >= {1'b0, span});
			valid_d[i]     = prev_valid;
			stage_d[i].rem = ge ? diff[PW_W-1:0] : shifted[PW_W-1:0];
			stage_d[i].nq  = {prev.nq[PCT_W-2:0], ge};
			stage_d[i].ctx = prev.ctx;
		end
	end

	// Final percent, mirrored when the channel is reversed.
	always_comb begin
		case (stage_s[PCT_STEPS-1].ctx.sel)
			PCT_LOW:  pct_d = cfg.reversed ? PCT_FULL : '0;
			PCT_HIGH: pct_d = cfg.reversed ? '0 : PCT_FULL;
			default:  pct_d = cfg.reversed ? (PCT_FULL - stage_s[PCT_STEPS-1].nq)
				: stage_s[PCT_STEPS-1].nq;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PCT_STEPS; i++) begin
				valid_s[i] <= 1'b0;
			end
			done_s8 <= 1'b0;
		end else begin
			for (int i = 0; i < PCT_STEPS; i++) begin
				valid_s[i] <= valid_d[i];
			end
			done_s8 <= valid_s[PCT_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < PCT_STEPS; i++) begin
			stage_s[i] <= stage_d[i];
		end
		pulse_s8   <= stage_s[PCT_STEPS-1].ctx.pulse;
		clamped_s8 <= stage_s[PCT_STEPS-1].ctx.clamped;
		pct_s8     <= pct_d;
	end

	assign done             = done_s8;
	assign pulse_width      = pulse_s8;
	assign was_clamped      = clamped_s8;
	assign percent_position = pct_s8;

endmodule

### src/rc_servo_pwm_mapper_top.sv
// Top level of the servo pulse mapper: configuration registers and the
// pipeline chain. Depends on rcspm_pkg, rcspm_front, rcspm_div, rcspm_post, rcspm_pct.

// Maps a signed control value to a clamped servo pulse width, a clamp flag
// and a percent position. A control value is taken on every clock edge at
// which start is high; busy is always low, so one transaction can enter in
// every cycle. Each result appears for one cycle, marked by done; results
// leave in order and cannot be held off. The depth is set by the 30-stage
// restoring divider (one quotient bit per stage) that forms the rounded range
// and angle terms, plus a 7-stage divider for the percent. Registers are
// written through cfg_we, cfg_index and cfg_data and should only change while
// no transaction is in flight.
module rc_servo_pwm_mapper_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [rcspm_pkg::VAL_W-1:0]   control_value,
	input  logic                                 cfg_we,
	input  logic [rcspm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rcspm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                 done,
	output logic [rcspm_pkg::PW_W-1:0]           pulse_width,
	output logic                                 was_clamped,
	output logic [rcspm_pkg::PCT_W-1:0]          percent_position
);
	import rcspm_pkg::*;

	cfg_t     cfg_q;
	div_req_t div_req;
	div_rsp_t div_rsp;
	pct_req_t pct_req;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= RST_MODE;
			cfg_q.reversed   <= RST_REVERSED;
			cfg_q.span_low   <= RST_SPAN_LOW;
			cfg_q.span_high  <= RST_SPAN_HIGH;
			cfg_q.pulse_min  <= RST_PULSE_MIN;
			cfg_q.pulse_max  <= RST_PULSE_MAX;
			cfg_q.pulse_trim <= RST_PULSE_TRIM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:       cfg_q.mode       <= cfg_data[1:0];
				REG_REVERSED:   cfg_q.reversed   <= cfg_data[0];
				REG_SPAN_LOW:   cfg_q.span_low   <= cfg_data;
				REG_SPAN_HIGH:  cfg_q.span_high  <= cfg_data;
				REG_PULSE_MIN:  cfg_q.pulse_min  <= cfg_data[PW_W-1:0];
				REG_PULSE_MAX:  cfg_q.pulse_max  <= cfg_data[PW_W-1:0];
				REG_PULSE_TRIM: cfg_q.pulse_trim <= cfg_data[PW_W-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline never stalls.
	assign busy = 1'b0;

	rcspm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.control_value (control_value),
		.cfg           (cfg_q),
		.req           (div_req)
	);

	rcspm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rcspm_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.rsp    (div_rsp),
		.cfg    (cfg_q),
		.req    (pct_req)
	);

	rcspm_pct u_pct (
		.clk              (clk),
		.arst_n           (arst_n),
		.req              (pct_req),
		.cfg              (cfg_q),
		.done             (done),
		.pulse_width      (pulse_width),
		.was_clamped      (was_clamped),
		.percent_position (percent_position)
	);

`ifndef NO_ASSERTIONS
	// Every result traces back to a start exactly one pipeline depth earlier.
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, PIPE_DEPTH))
		else $error("done without a start one pipeline depth earlier");

	// The divider keeps its latency: no item appears early or out of thin air.
	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.valid |-> $past(div_req.valid, DIV_STEPS))
		else $error("divider output valid without matching input");
`endif

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the servo pulse mapper: directed and random
// control values under many register settings, checked against an in-bench model.
// Depends on rcspm_pkg and rc_servo_pwm_mapper_top.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rcspm_pkg::*;

	typedef struct packed {
		logic [PW_W-1:0]  pulse;
		logic             clamped;
		logic [PCT_W-1:0] pct;
	} servo_pulse_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [VAL_W-1:0] control_value;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    done;
	logic [PW_W-1:0]         pulse_width;
	logic                    was_clamped;
	logic [PCT_W-1:0]        percent_position;

	// Register copy used for prediction and the results still in flight.
	cfg_t         servo_cfg;
	servo_pulse_t pending_pulses[$];
	int           error_count = 0;

	rc_servo_pwm_mapper_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.control_value    (control_value),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.done             (done),
		.pulse_width      (pulse_width),
		.was_clamped      (was_clamped),
		.percent_position (percent_position)
	);

	always #5 clk = ~clk;

	// Quotient rounded to nearest, ties away from zero.
	function automatic longint div_round_away(input longint num, input longint den);
		longint an;
		longint ad;
		longint q;
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		q = (2 * an + ad) / (2 * ad);
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	// Expected pulse, clamp flag and percent for one control value.
	function automatic servo_pulse_t predict_pulse(input logic signed [VAL_W-1:0] v);
		longint       val;
		longint       mn;
		longint       mx;
		longint       trim;
		longint       lo;
		longint       hi;
		longint       dir;
		longint       term;
		longint       o;
		longint       pct;
		servo_pulse_t res;
		val = longint'(v);
		mn = longint'(servo_cfg.pulse_min);
		mx = longint'(servo_cfg.pulse_max);
		trim = longint'(servo_cfg.pulse_trim);
		lo = longint'(servo_cfg.span_low);
		hi = longint'(servo_cfg.span_high);
		dir = servo_cfg.reversed ? -1 : 1;
		case (servo_cfg.mode)
			MODE_RANGE: begin
				// A zero span falls back to the trim value as the term.
				if (hi == lo)
					term = trim;
				else
					term = div_round_away((val - lo) * (mx - mn), hi - lo);
				o = servo_cfg.reversed ? (mx - term) : (mn + term);
			end
			MODE_RAW: begin
				term = val / 10;
				o = term * dir + trim;
			end
			default: begin
				// Angle mode, also taken by the spare mode code.
				if (hi == 0)
					term = 0;
				else if (val * dir > 0)
					term = div_round_away(dir * val * (mx - trim), hi);
				else
					term = div_round_away(dir * val * (trim - mn), hi);
				o = term + trim;
			end
		endcase
		if (o < mn)
			res.pulse = mn[PW_W-1:0];
		else if (o > mx)
			res.pulse = mx[PW_W-1:0];
		else
			res.pulse = o[PW_W-1:0];
		res.clamped = (o < mn) || (o > mx);
		// Percent is taken from the unclamped pulse.
		if (o <= mn) begin
			pct = servo_cfg.reversed ? 100 : 0;
		end else if (o >= mx) begin
			pct = servo_cfg.reversed ? 0 : 100;
		end else begin
			pct = (100 * (o - mn)) / (mx - mn);
			if (servo_cfg.reversed)
				pct = 100 - pct;
		end
		res.pct = pct[PCT_W-1:0];
		return res;
	endfunction

	function automatic cfg_t make_cfg(input logic [1:0] mode, input logic rev,
			input int lo, input int hi, input int mn, input int mx, input int trim);
		cfg_t c;
		c.mode = mode;
		c.reversed = rev;
		c.span_low = lo[VAL_W-1:0];
		c.span_high = hi[VAL_W-1:0];
		c.pulse_min = mn[PW_W-1:0];
		c.pulse_max = mx[PW_W-1:0];
		c.pulse_trim = trim[PW_W-1:0];
		return c;
	endfunction

	// Mostly plausible settings, sometimes fully random fields or degenerate spans.
	function automatic cfg_t random_settings();
		cfg_t c;
		int   m;
		int   lo;
		int   hi;
		int   mn;
		int   mx;
		m = int'($urandom_range(0, 7));
		c.mode = (m < 7) ? 2'(m % 3) : MODE_SPARE;
		c.reversed = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 4) == 0) begin
			c.pulse_min = PW_W'($urandom);
			c.pulse_max = PW_W'($urandom);
			c.pulse_trim = PW_W'($urandom);
		end else begin
			mn = int'($urandom_range(500, 1400));
			mx = int'($urandom_range(1600, 2500));
			c.pulse_min = PW_W'(mn);
			c.pulse_max = PW_W'(mx);
			c.pulse_trim = PW_W'($urandom_range(mn, mx));
		end
		if ($urandom_range(0, 4) == 0) begin
			c.span_low = VAL_W'($urandom);
			c.span_high = VAL_W'($urandom);
		end else begin
			lo = int'($urandom_range(10000, 0)) - 5000;
			hi = lo + int'($urandom_range(9000, 0)) * (($urandom_range(0, 3) == 0) ? -1 : 1);
			c.span_low = lo[VAL_W-1:0];
			c.span_high = hi[VAL_W-1:0];
		end
		if ($urandom_range(0, 9) == 0)
			c.span_high = c.span_low;
		if ($urandom_range(0, 9) == 0)
			c.span_high = '0;
		return c;
	endfunction

	// Control value: mostly inside the active span of the mode, else anywhere.
	function automatic logic signed [VAL_W-1:0] pick_value();
		int a;
		int b;
		int t;
		if ($urandom_range(0, 3) == 0)
			return VAL_W'($urandom);
		case (servo_cfg.mode)
			MODE_RANGE: begin
				a = int'(servo_cfg.span_low);
				b = int'(servo_cfg.span_high);
			end
			MODE_RAW: begin
				a = -12000;
				b = 12000;
			end
			default: begin
				b = int'(servo_cfg.span_high);
				if (b < 0)
					b = -b;
				a = -b;
			end
		endcase
		if (a > b) begin
			t = a;
			a = b;
			b = t;
		end
		t = a + int'($urandom_range(b - a, 0));
		if (t > 32767)
			t = 32767;
		return t[VAL_W-1:0];
	endfunction

	// Result checker: each strobed result is matched against the oldest prediction.
	always @(negedge clk) begin
		servo_pulse_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_pulses.size() == 0) begin
				$display("%0t: unexpected result: expected none, got pw=%0d clamp=%0d pct=%0d",
					$time, pulse_width, was_clamped, percent_position);
				error_count++;
			end else begin
				want = pending_pulses.pop_front();
				if (pulse_width !== want.pulse) begin
					$display("%0t: pulse_width expected %0d, got %0d",
						$time, want.pulse, pulse_width);
					error_count++;
				end
				if (was_clamped !== want.clamped) begin
					$display("%0t: was_clamped expected %0d, got %0d",
						$time, want.clamped, was_clamped);
					error_count++;
				end
				if (percent_position !== want.pct) begin
					$display("%0t: percent_position expected %0d, got %0d",
						$time, want.pct, percent_position);
					error_count++;
				end
			end
		end
	end

	// Sends one control value after an optional idle gap; start stays high afterwards.
	task automatic send_value(input logic signed [VAL_W-1:0] v, input int gap);
		bit taken;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		control_value <= v;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		pending_pulses.push_back(predict_pulse(v));
	endtask

	function automatic int random_gap(input bit idling);
		if (!idling || $urandom_range(0, 3) != 0)
			return 0;
		return int'($urandom_range(1, 16));
	endfunction

	// Stops new transactions and waits until every result has come back.
	task automatic wait_for_idle();
		start <= 1'b0;
		while (pending_pulses.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Writes all seven registers; only called while the block is idle.
	task automatic load_settings(input cfg_t c);
		wait_for_idle();
		write_reg(REG_MODE, {{(CFG_DATA_W-2){1'b0}}, c.mode});
		write_reg(REG_REVERSED, {{(CFG_DATA_W-1){1'b0}}, c.reversed});
		write_reg(REG_SPAN_LOW, c.span_low);
		write_reg(REG_SPAN_HIGH, c.span_high);
		write_reg(REG_PULSE_MIN, {{(CFG_DATA_W-PW_W){1'b0}}, c.pulse_min});
		write_reg(REG_PULSE_MAX, {{(CFG_DATA_W-PW_W){1'b0}}, c.pulse_max});
		write_reg(REG_PULSE_TRIM, {{(CFG_DATA_W-PW_W){1'b0}}, c.pulse_trim});
		cfg_we <= 1'b0;
		servo_cfg = c;
	endtask

	// Angle mode with the settings left by reset.
	task automatic test_reset_angle();
		send_value(-16'sd32768, 0);
		send_value(16'sd32767, 0);
		send_value(16'sd0, 0);
		send_value(16'sd4500, 0);
		send_value(-16'sd2250, 0);
	endtask

	// Range mapping, mirrored, with a zero span and with the widest span.
	task automatic test_range_mode();
		load_settings(make_cfg(MODE_RANGE, 1'b0, -1000, 1000, 1000, 2000, 1500));
		send_value(-16'sd1000, 0);
		send_value(16'sd1000, 0);
		send_value(16'sd1, 0);
		load_settings(make_cfg(MODE_RANGE, 1'b1, -1000, 1000, 1000, 2000, 1500));
		send_value(-16'sd1000, 0);
		send_value(16'sd333, 0);
		load_settings(make_cfg(MODE_RANGE, 1'b0, 700, 700, 900, 2100, 1200));
		send_value(16'sd5, 0);
		load_settings(make_cfg(MODE_RANGE, 1'b0, -32768, 32767, 0, 4095, 2048));
		send_value(-16'sd32768, 0);
		send_value(16'sd32767, 0);
	endtask

	// Angle mapping reversed, then with a zero scale.
	task automatic test_angle_mode();
		load_settings(make_cfg(MODE_ANGLE, 1'b1, 0, 3000, 1000, 2000, 1400));
		send_value(16'sd1000, 0);
		send_value(-16'sd1000, 0);
		load_settings(make_cfg(MODE_ANGLE, 1'b0, 0, 0, 1000, 2000, 1400));
		send_value(16'sd12345, 0);
	endtask

	// Raw tenths: truncation toward zero in both signs and in both directions.
	task automatic test_raw_mode();
		load_settings(make_cfg(MODE_RAW, 1'b0, 0, 0, 1000, 2000, 1500));
		send_value(16'sd15, 0);
		send_value(-16'sd15, 0);
		load_settings(make_cfg(MODE_RAW, 1'b1, 0, 0, 0, 4095, 4095));
		send_value(-16'sd32768, 0);
		send_value(16'sd32767, 0);
	endtask

	// The spare mode code must behave as angle mode.
	task automatic test_unused_mode();
		load_settings(make_cfg(MODE_SPARE, 1'b0, 0, 4500, 1100, 1900, 1500));
		send_value(16'sd2000, 0);
		send_value(-16'sd3000, 0);
	endtask

	// Minimum above maximum: the clamp picks one of the two bounds.
	task automatic test_crossed_bounds();
		load_settings(make_cfg(MODE_RAW, 1'b0, 0, 0, 2000, 1000, 1500));
		send_value(16'sd0, 0);
		send_value(16'sd9000, 0);
	endtask

	// Random settings and values with random idling; the last phase runs back to back.
	task automatic test_random_traffic();
		cfg_t c;
		for (int p = 0; p < 8; p++) begin
			c = random_settings();
			if (p == 1) begin
				c.span_low = 16'h8000;
				c.span_high = 16'h7fff;
				c.pulse_min = '0;
				c.pulse_max = '1;
			end else if (p == 2) begin
				c.span_low = 16'h7fff;
				c.span_high = 16'h8000;
				c.reversed = 1'b1;
			end
			load_settings(c);
			for (int i = 0; i < 50; i++)
				send_value(pick_value(), random_gap(p != 7));
		end
	endtask

	initial begin
		start <= 1'b0;
		control_value <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		arst_n <= 1'b0;
		servo_cfg = make_cfg(RST_MODE, RST_REVERSED, int'($signed(RST_SPAN_LOW)),
			int'($signed(RST_SPAN_HIGH)), int'(RST_PULSE_MIN), int'(RST_PULSE_MAX),
			int'(RST_PULSE_TRIM));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_angle();
		test_range_mode();
		test_angle_mode();
		test_raw_mode();
		test_unused_mode();
		test_crossed_bounds();
		test_random_traffic();
		wait_for_idle();
		// Leave room for any stray result to show up.
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// Watchdog for a hung handshake or missing results.
	initial begin
		#2000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
